// ===== hw/rtl/bfaq_pkg.sv =====
// Shared types and constants of the budget FIFO admission queue.
`default_nettype none
package bfaq_pkg;

	localparam int unsigned REQ_TYPE_W = 2;
	localparam int unsigned REQ_ID_W = 32;
	localparam int unsigned BUDGET_W = 8;
	localparam int unsigned QCOUNT_W = 5;
	localparam logic [BUDGET_W-1:0] GRANTS_PER_PERIOD_RST = 8'd4;
	localparam int unsigned CMDQ_DEPTH = 2;

	// Request codes on the input channel.
	localparam logic [REQ_TYPE_W-1:0] REQ_ADMIT = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_ABORT = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd2;

	// Operation class decided by the front end.
	typedef enum logic [1:0] {
		OP_ADMIT,
		OP_ABORT,
		OP_TICK,
		OP_IGNORE
	} op_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [REQ_ID_W-1:0]   req_id;
	} in_item_t;

	typedef struct packed {
		logic                granted;
		logic                now_waiting;
		logic                dropped;
		logic [BUDGET_W-1:0] budget_left;
		logic [QCOUNT_W-1:0] queue_count;
	} out_item_t;

	typedef struct packed {
		op_t                 op;
		logic [REQ_ID_W-1:0] id;
	} cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfaq_front.sv =====
// Front end: accepts input items, classifies them and masks the requester id.
`default_nettype none
module bfaq_front #(
	parameter int unsigned ID_BITS = 32
) (
	input  wire  bfaq_pkg::in_item_t req,
	input  wire  logic               push,
	input  wire  logic               cmdq_full,
	output bfaq_pkg::cmd_t           cmd,
	output logic                     cmd_wr
);
	import bfaq_pkg::*;

	localparam int unsigned ID_W = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;

	always_comb begin
		cmd_wr = push && !cmdq_full;
		for (int i = 0; i < REQ_ID_W; i++) begin
			cmd.id[i] = (i < ID_W) ? req.req_id[i] : 1'b0;
		end
		unique case (req.req_type)
			REQ_ADMIT: cmd.op = OP_ADMIT;
			REQ_ABORT: cmd.op = OP_ABORT;
			REQ_TICK:  cmd.op = OP_TICK;
			default:   cmd.op = OP_IGNORE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bfaq_cmdq.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module bfaq_cmdq (
	input  wire  logic           clk,
	input  wire  logic           arst_n,
	input  wire  logic           wr,
	input  wire  bfaq_pkg::cmd_t wr_cmd,
	output logic                 full,
	input  wire  logic           rd,
	output bfaq_pkg::cmd_t       rd_cmd,
	output logic                 rd_valid
);
	import bfaq_pkg::*;

	localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bfaq_back.sv =====
// Back end: shift queue of waiting ids, grant budget and the result register.
`default_nettype none
module bfaq_back #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 32
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_we,
	input  wire  logic [bfaq_pkg::BUDGET_W-1:0] cfg_wdata,
	input  wire  bfaq_pkg::cmd_t                cmd,
	input  wire  logic                          cmd_valid,
	output logic                                cmd_rd,
	output bfaq_pkg::out_item_t                 rsp,
	output logic                                empty,
	input  wire  logic                          pop
);
	import bfaq_pkg::*;

	localparam int unsigned ID_W  = (ID_BITS < REQ_ID_W) ? ID_BITS : REQ_ID_W;
	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ID_W-1:0]     cell_q [QUEUE_DEPTH];
	logic [ID_W-1:0]     cell_d [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [BUDGET_W-1:0] grants_q;
	logic [BUDGET_W-1:0] grants_d;
	logic [BUDGET_W-1:0] period_q;
	logic                rsp_valid_q;
	out_item_t           rsp_q;
	out_item_t           rsp_d;

	logic [ID_W-1:0]        id;
	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH-1:0] at_or_after;
	logic                   any_match;
	logic                   q_full;
	logic                   do_remove;
	logic                   do_append;
	logic [CNT_W+QCOUNT_W-1:0] count_ext;

	assign id     = cmd.id[ID_W-1:0];
	assign cmd_rd = cmd_valid && (!rsp_valid_q || pop);
	assign empty  = !rsp_valid_q;
	assign rsp    = rsp_q;

	// Every cell compares itself against the id; ids in the queue are unique.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (cell_q[i] == id);
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			at_or_after[i] = |(match & ((QUEUE_DEPTH'(1) << i) |
				((QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1))));
		end
	end

	assign any_match = |match;
	assign q_full    = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		grants_d  = grants_q;
		count_d   = count_q;
		do_remove = 1'b0;
		do_append = 1'b0;
		rsp_d     = '0;
		unique case (cmd.op)
			OP_ADMIT: begin
				if (grants_q != '0 && (count_q == '0 || match[0])) begin
					rsp_d.granted = 1'b1;
					grants_d      = grants_q - 1'b1;
					do_remove     = match[0];
				end else if (any_match) begin
					rsp_d.now_waiting = 1'b1;
				end else if (!q_full) begin
					rsp_d.now_waiting = 1'b1;
					do_append         = 1'b1;
				end else begin
					rsp_d.dropped = 1'b1;
				end
			end
			OP_ABORT: begin
				do_remove = any_match;
			end
			OP_TICK: begin
				grants_d = period_q;
			end
			OP_IGNORE: begin
			end
			default: begin
			end
		endcase
		if (do_remove) begin
			count_d = count_q - 1'b1;
		end else if (do_append) begin
			count_d = count_q + 1'b1;
		end
		count_ext         = {{QCOUNT_W{1'b0}}, count_d};
		rsp_d.budget_left = grants_d;
		rsp_d.queue_count = count_ext[QCOUNT_W-1:0];
	end

	// Removal shifts every cell at or behind the hit one place toward the head.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			cell_d[i] = cell_q[i];
			if (do_remove && at_or_after[i] && i < QUEUE_DEPTH - 1) begin
				cell_d[i] = cell_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
			end
			if (do_append && IDX_W'(i) == count_q[IDX_W-1:0]) begin
				cell_d[i] = id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				cell_q[i] <= cell_d[i];
			end
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			grants_q    <= '0;
			period_q    <= GRANTS_PER_PERIOD_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (cmd_rd) begin
				count_q     <= count_d;
				grants_q    <= grants_d;
				rsp_valid_q <= 1'b1;
			end else if (pop) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/budget_fifo_admission_queue_core.sv =====
// A pushed item goes into the command queue; the back end takes it from there
// and registers its result. One item per cycle while neither side stalls;
// requests are decided by per-cell compare and shift in the waiting queue.
// A two-entry command queue lets input and result sides stall independently.
// Reset clears the waiting count, the budget and both queues; the budget
// register returns to four grants per period. Id cells are not cleared.
`default_nettype none
module budget_fifo_admission_queue_core #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 32
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          push,
	output logic                                full,
	input  wire  bfaq_pkg::in_item_t            req,
	output logic                                empty,
	input  wire  logic                          pop,
	output bfaq_pkg::out_item_t                 rsp,
	input  wire  logic                          cfg_we,
	input  wire  logic [bfaq_pkg::BUDGET_W-1:0] cfg_wdata
);
	import bfaq_pkg::*;

	cmd_t front_cmd;
	logic front_wr;
	cmd_t back_cmd;
	logic back_valid;
	logic back_rd;

	bfaq_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.req      (req),
		.push     (push),
		.cmdq_full(full),
		.cmd      (front_cmd),
		.cmd_wr   (front_wr)
	);

	bfaq_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (front_wr),
		.wr_cmd  (front_cmd),
		.full    (full),
		.rd      (back_rd),
		.rd_cmd  (back_cmd),
		.rd_valid(back_valid)
	);

	bfaq_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (back_cmd),
		.cmd_valid(back_valid),
		.cmd_rd   (back_rd),
		.rsp      (rsp),
		.empty    (empty),
		.pop      (pop)
	);

endmodule
`default_nettype wire
